// ===== sv/isfp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// isfp_pkg: shared types and constants for the IMU serial frame parser
// Frame byte codes, position markers, the result record and queue status.
// ---------------------------------------------------------------------------
package isfp_pkg;

  // Frame byte codes
  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACCEL  = 8'h51;
  localparam logic [7:0] TYPE_RATE   = 8'h52;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;

  // Byte positions inside a frame
  localparam logic [3:0] POS_HUNT     = 4'd0;
  localparam logic [3:0] POS_TYPE     = 4'd1;
  localparam logic [3:0] POS_DATA0    = 4'd2;
  localparam logic [3:0] POS_DATA_END = 4'd8;   // first position past the stored data bytes
  localparam logic [3:0] POS_SUM      = 4'd10;

  localparam int PAYLOAD_COUNT = 6;

  // Result queue depth between framing and output stages
  localparam int QUEUE_DEPTH = 2;

  // Reading kinds
  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_RATE  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } reading_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

// ===== sv/isfp_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// isfp_front: byte framing stage
// Hunts for the header, collects type, data and sum bytes, and pushes one
// reading into the queue for each good frame of a known type.
// ---------------------------------------------------------------------------
module isfp_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    end_of_message,
  input  wire isfp_pkg::queue_status_t q_status,
  output logic                         push,
  output isfp_pkg::reading_t           push_data
);

  logic [3:0] byte_position, byte_position_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] frame_type;
  logic [7:0] payload_bytes [isfp_pkg::PAYLOAD_COUNT];
  logic       accept;
  logic       type_known;
  logic       sum_good;
  logic [3:0] data_offset;
  logic [2:0] data_index;

  // Accept a beat whenever the queue has room
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  assign data_offset = byte_position - isfp_pkg::POS_DATA0;
  assign data_index  = data_offset[2:0];

  always_comb begin
    type_known = frame_type inside {[isfp_pkg::TYPE_ACCEL : isfp_pkg::TYPE_ANGLE]};
    sum_good   = running_sum == data_byte;
  end

  // Next position and running sum
  always_comb begin
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    push               = 1'b0;
    if (accept) begin
      if (byte_position == isfp_pkg::POS_HUNT || byte_position > isfp_pkg::POS_SUM) begin
        byte_position_next = isfp_pkg::POS_HUNT;
        if (data_byte == isfp_pkg::HEADER_BYTE) begin
          byte_position_next = isfp_pkg::POS_TYPE;
          running_sum_next   = isfp_pkg::HEADER_BYTE;
        end
      end else if (byte_position < isfp_pkg::POS_SUM) begin
        running_sum_next   = running_sum + data_byte;
        byte_position_next = byte_position + 4'd1;
      end else begin
        byte_position_next = isfp_pkg::POS_HUNT;
        running_sum_next   = 8'd0;
        push               = sum_good && type_known;
      end
      // Drop a partial frame at message end
      if (end_of_message && byte_position_next != isfp_pkg::POS_HUNT) begin
        byte_position_next = isfp_pkg::POS_HUNT;
        running_sum_next   = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= isfp_pkg::POS_HUNT;
      running_sum   <= 8'd0;
    end else begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
    end
  end

  // Capture type and data bytes
  always_ff @(posedge clk) begin
    if (accept && byte_position == isfp_pkg::POS_TYPE) begin
      frame_type <= data_byte;
    end
    if (accept && byte_position >= isfp_pkg::POS_DATA0 &&
        byte_position < isfp_pkg::POS_DATA_END) begin
      payload_bytes[data_index] <= data_byte;
    end
  end

  // Assemble the little-endian counts
  always_comb begin
    push_data.kind = 2'(frame_type - isfp_pkg::TYPE_ACCEL);
    push_data.x    = {payload_bytes[1], payload_bytes[0]};
    push_data.y    = {payload_bytes[3], payload_bytes[2]};
    push_data.z    = {payload_bytes[5], payload_bytes[4]};
  end

endmodule
`default_nettype wire

// ===== sv/isfp_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// isfp_queue: small reading queue
// Register-based FIFO that decouples framing from the output stage.
// ---------------------------------------------------------------------------
module isfp_queue #(
  parameter int DEPTH = isfp_pkg::QUEUE_DEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire isfp_pkg::reading_t      push_data,
  input  wire logic                    pop,
  output isfp_pkg::reading_t           pop_data,
  output isfp_pkg::queue_status_t      status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  isfp_pkg::reading_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign status.full  = count == CNT_W'(DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entries[rd_ptr];

  // Store a pushed reading
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/isfp_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// isfp_back: output stage
// Pops readings from the queue into the output register and holds each
// one until the downstream side takes the beat.
// ---------------------------------------------------------------------------
module isfp_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire isfp_pkg::queue_status_t q_status,
  input  wire isfp_pkg::reading_t      q_data,
  output logic                         pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   reading_kind,
  output logic signed [15:0]           axis_x,
  output logic signed [15:0]           axis_y,
  output logic signed [15:0]           axis_z
);

  isfp_pkg::reading_t hold;

  // Load when the register is empty or being drained
  assign pop = !q_status.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold <= q_data;
    end
  end

  assign reading_kind = hold.kind;
  assign axis_x       = hold.x;
  assign axis_y       = hold.y;
  assign axis_z       = hold.z;

endmodule
`default_nettype wire

// ===== sv/imu_serial_frame_parser.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// imu_serial_frame_parser: sum-checked 11-byte sensor frame parser
// Framing front end, reading queue and registered output stage.
// ---------------------------------------------------------------------------
// The parser takes one byte per clock cycle. Each byte is framed in the
// cycle it is accepted; the reading of a frame is queued when its
// checksum byte is accepted and then moves to the output register. Input
// stalls only when the reading queue (QUEUE_DEPTH entries) and the output
// register are all occupied because the downstream side is not taking
// beats, so with a ready consumer the sustained rate is one byte per cycle.
module imu_serial_frame_parser #(
  parameter int QUEUE_DEPTH = isfp_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_message,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              reading_kind,
  output logic signed [15:0]      axis_x,
  output logic signed [15:0]      axis_y,
  output logic signed [15:0]      axis_z
);

  isfp_pkg::queue_status_t q_status;
  isfp_pkg::reading_t      push_data;
  isfp_pkg::reading_t      pop_data;
  logic                    push;
  logic                    pop;

  isfp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .q_status       (q_status),
    .push           (push),
    .push_data      (push_data)
  );

  isfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  isfp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .q_data       (pop_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reading_kind (reading_kind),
    .axis_x       (axis_x),
    .axis_y       (axis_y),
    .axis_z       (axis_z)
  );

endmodule
`default_nettype wire

// ===== sv/isfp_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// isfp_checker: port-level checks for the frame parser
// Watches the top-level ports and flags output and stall behavior that
// the framing and queue logic must never show.
// ---------------------------------------------------------------------------
module isfp_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [1:0]         reading_kind,
  input  wire logic signed [15:0] axis_x,
  input  wire logic signed [15:0] axis_y,
  input  wire logic signed [15:0] axis_z
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reading_kind) &&
      $stable(axis_x) && $stable(axis_y) && $stable(axis_z))
    else $error("stalled result beat changed");

  // Only the three known reading kinds leave the block
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reading_kind != 2'd3)
    else $error("unknown reading kind on output");

  // Reset empties the output stage
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // Keep the input handshake signals in view for stall checks
  a_stall_seen: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid && !out_ready || out_valid)
    else $error("input stall without a pending result");

endmodule

bind imu_serial_frame_parser isfp_checker u_isfp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .reading_kind (reading_kind),
  .axis_x       (axis_x),
  .axis_y       (axis_y),
  .axis_z       (axis_z)
);
`default_nettype wire
